### rtl/core/mcsd_pkg.sv
// ----------------------------------------------------------------------------
// mcsd_pkg
// Shared types, constants and the channel qualification function of the
// multi-channel switch debouncer.
// ----------------------------------------------------------------------------
package mcsd_pkg;

	localparam int MAX_CHANNELS  = 24;
	localparam int DEF_TIME_BITS = 32;

	localparam int CHAN_W     = 5;
	localparam int SLOT_W     = 5;
	localparam int MS_W       = 16;
	localparam int MASK_W     = 24;
	localparam int MAP_W      = 60;
	localparam int CFG_W      = 60;
	localparam int CFG_IDX_W  = 3;
	localparam int SW_W       = 24;
	localparam int NOW_W      = 32;
	localparam int IN_TDATA_W = 56;
	localparam int OUT_TDATA_W = 16;
	localparam int MAP_SPLIT  = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOT_COUNT    = 3'd0,
		REG_TRACKED_MASK  = 3'd1,
		REG_IGNORED_MASK  = 3'd2,
		REG_DEBOUNCE_MS   = 3'd3,
		REG_FALLBACK_MS   = 3'd4,
		REG_SLOT_MAP_LOW  = 3'd5,
		REG_SLOT_MAP_HIGH = 3'd6
	} reg_idx_t;

	// per-channel settings handed to a cell
	typedef struct packed {
		logic [SLOT_W-1:0] slot;  // 0: channel does not qualify
		logic [MS_W-1:0]   req;   // required stable time
	} cell_cfg_t;

	typedef struct packed {
		logic              valid;
		logic [CHAN_W-1:0] channel;
		logic [SLOT_W-1:0] slot;
		logic              occupied;
	} evt_t;

	// slot 1..count, or 0 when the channel is out of use or its map entry exceeds count
	function automatic logic [SLOT_W-1:0] qualify(
		input logic [CHAN_W-1:0] ch,
		input logic [SLOT_W-1:0] count,
		input logic              tracked,
		input logic              ignored,
		input logic [SLOT_W-1:0] entry
	);
		logic [SLOT_W-1:0] slot;
		slot = '0;
		if (ch < count && tracked && !ignored) begin
			if (entry == '0)
				slot = ch + 5'd1;
			else if (entry <= count)
				slot = entry;
		end
		return slot;
	endfunction

endpackage

### rtl/core/multi_channel_switch_debouncer.sv
// ----------------------------------------------------------------------------
// multi_channel_switch_debouncer
// Time-based debouncer for up to 24 switch channels, one cell per channel.
//
//   group   | signals                     | content (low bits first)
//   --------+-----------------------------+-----------------------------------
//   s_*     | s_tvalid s_tready s_tdata   | switch_bits[23:0], now_ms[55:24]
//   m_*     | m_tvalid m_tready m_tdata   | event_channel[4:0], event_slot[9:5],
//           | m_tlast                     | event_occupied[10]; tlast=event_last
//   cfg_*   | cfg_we cfg_index cfg_wdata  | register write, no read-back
//
// A snapshot walks the cell row one cell per cycle while the output register
// is not stalled; after the last cell it sets flush_q, and then its last
// event moves from hold_q into the output register with tlast. The next
// snapshot is accepted the cycle after, as busy clears with that move.
// A stalled output register freezes the whole row.
// Reset clears all channel state; the first snapshot commits directly.
// ----------------------------------------------------------------------------
module multi_channel_switch_debouncer #(
	parameter int CHANNELS  = mcsd_pkg::MAX_CHANNELS,
	parameter int TIME_BITS = mcsd_pkg::DEF_TIME_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [mcsd_pkg::IN_TDATA_W-1:0]    s_tdata,   // switch_bits, now_ms
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [mcsd_pkg::OUT_TDATA_W-1:0]   m_tdata,   // event_channel, event_slot, event_occupied
	output logic                               m_tlast,
	input  logic                               cfg_we,
	input  logic [mcsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mcsd_pkg::CFG_W-1:0]         cfg_wdata
);
	import mcsd_pkg::*;

	// configuration
	logic [SLOT_W-1:0] slot_count_q;
	logic [MASK_W-1:0] tracked_q;
	logic [MASK_W-1:0] ignored_q;
	logic [MS_W-1:0]   debounce_q;
	logic [MS_W-1:0]   fallback_q;
	logic [MAP_W-1:0]  map_low_q;
	logic [MAP_W-1:0]  map_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_W'(MAX_CHANNELS);
			tracked_q    <= '1;
			ignored_q    <= '0;
			debounce_q   <= '0;
			fallback_q   <= '0;
			map_low_q    <= '0;
			map_high_q   <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SLOT_COUNT:    slot_count_q <= cfg_wdata[SLOT_W-1:0];
				REG_TRACKED_MASK:  tracked_q    <= cfg_wdata[MASK_W-1:0];
				REG_IGNORED_MASK:  ignored_q    <= cfg_wdata[MASK_W-1:0];
				REG_DEBOUNCE_MS:   debounce_q   <= cfg_wdata[MS_W-1:0];
				REG_FALLBACK_MS:   fallback_q   <= cfg_wdata[MS_W-1:0];
				REG_SLOT_MAP_LOW:  map_low_q    <= cfg_wdata[MAP_W-1:0];
				REG_SLOT_MAP_HIGH: map_high_q   <= cfg_wdata[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	logic [SLOT_W-1:0] eff_count;
	logic [MS_W-1:0]   req;

	assign eff_count = (slot_count_q > SLOT_W'(CHANNELS)) ? SLOT_W'(CHANNELS) : slot_count_q;
	assign req       = (debounce_q > fallback_q) ? debounce_q : fallback_q;

	// control
	logic busy_q;
	logic primed_q;
	logic flush_q;
	evt_t hold_q;
	logic adv;
	logic accept;

	logic                   m_valid_q;
	logic [CHAN_W-1:0]      m_chan_q;
	logic [SLOT_W-1:0]      m_slot_q;
	logic                   m_occ_q;
	logic                   m_last_q;

	assign adv      = !m_valid_q || m_tready;
	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;

	// token row: index 0 is the input register, index i+1 is cell i's output
	logic                 tok_valid  [CHANNELS+1];
	logic                 tok_primed [CHANNELS+1];
	logic [TIME_BITS-1:0] tok_now    [CHANNELS+1];
	logic [CHANNELS-1:0]  tok_bits   [CHANNELS+1];
	evt_t                 cell_evt   [CHANNELS];

	logic                 tok0_valid_q;
	logic                 tok0_primed_q;
	logic [TIME_BITS-1:0] tok0_now_q;
	logic [CHANNELS-1:0]  tok0_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_valid_q <= 1'b0;
			primed_q     <= 1'b0;
		end else if (accept) begin
			tok0_valid_q <= 1'b1;
			primed_q     <= 1'b1;
		end else if (adv) begin
			tok0_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok0_primed_q <= primed_q;
			tok0_bits_q   <= s_tdata[CHANNELS-1:0];
			tok0_now_q    <= TIME_BITS'(s_tdata[SW_W +: NOW_W]);
		end
	end

	assign tok_valid[0]  = tok0_valid_q;
	assign tok_primed[0] = tok0_primed_q;
	assign tok_now[0]    = tok0_now_q;
	assign tok_bits[0]   = tok0_bits_q;

	for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
		logic [SLOT_W-1:0] entry;
		cell_cfg_t         ccfg;

		if (i < MAP_SPLIT) begin : g_low
			assign entry = map_low_q[SLOT_W*i +: SLOT_W];
		end else begin : g_high
			assign entry = map_high_q[SLOT_W*(i-MAP_SPLIT) +: SLOT_W];
		end

		assign ccfg.slot = qualify(CHAN_W'(i), eff_count, tracked_q[i], ignored_q[i], entry);
		assign ccfg.req  = req;

		mcsd_cell #(
			.IDX       (i),
			.CHANNELS  (CHANNELS),
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.cfg        (ccfg),
			.in_valid   (tok_valid[i]),
			.in_primed  (tok_primed[i]),
			.in_now     (tok_now[i]),
			.in_bits    (tok_bits[i]),
			.out_valid  (tok_valid[i+1]),
			.out_primed (tok_primed[i+1]),
			.out_now    (tok_now[i+1]),
			.out_bits   (tok_bits[i+1]),
			.evt        (cell_evt[i])
		);
	end

	// only one snapshot is in the row, so at most one cell holds an event
	evt_t evt_sel;
	logic end_seen;

	always_comb begin
		evt_sel = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (tok_valid[i+1])
				evt_sel = evt_sel | cell_evt[i];
		end
	end

	assign end_seen = tok_valid[CHANNELS];

	// each event waits in hold_q until the next one releases it with tlast low, or the end releases it with tlast set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			flush_q   <= 1'b0;
			hold_q    <= '0;
			m_valid_q <= 1'b0;
			m_chan_q  <= '0;
			m_slot_q  <= '0;
			m_occ_q   <= 1'b0;
			m_last_q  <= 1'b0;
		end else begin
			if (m_tready)
				m_valid_q <= 1'b0;
			if (accept)
				busy_q <= 1'b1;
			if (adv) begin
				if (flush_q) begin
					if (hold_q.valid) begin
						m_valid_q <= 1'b1;
						m_chan_q  <= hold_q.channel;
						m_slot_q  <= hold_q.slot;
						m_occ_q   <= hold_q.occupied;
						m_last_q  <= 1'b1;
					end
					hold_q  <= '0;
					flush_q <= 1'b0;
					busy_q  <= 1'b0;
				end else begin
					if (evt_sel.valid) begin
						if (hold_q.valid) begin
							m_valid_q <= 1'b1;
							m_chan_q  <= hold_q.channel;
							m_slot_q  <= hold_q.slot;
							m_occ_q   <= hold_q.occupied;
							m_last_q  <= 1'b0;
						end
						hold_q <= evt_sel;
					end
					if (end_seen)
						flush_q <= 1'b1;
				end
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {{(OUT_TDATA_W - CHAN_W - SLOT_W - 1){1'b0}}, m_occ_q, m_slot_q, m_chan_q};

endmodule

### rtl/core/mcsd_cell.sv
// ----------------------------------------------------------------------------
// mcsd_cell
// One channel of the debouncer: raw bit, committed bit and change time.
// Processes the snapshot as it passes and hands it to the next cell.
// ----------------------------------------------------------------------------
module mcsd_cell #(
	parameter int IDX       = 0,
	parameter int CHANNELS  = mcsd_pkg::MAX_CHANNELS,
	parameter int TIME_BITS = mcsd_pkg::DEF_TIME_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  mcsd_pkg::cell_cfg_t   cfg,
	input  logic                  in_valid,
	input  logic                  in_primed,
	input  logic [TIME_BITS-1:0]  in_now,
	input  logic [CHANNELS-1:0]   in_bits,
	output logic                  out_valid,
	output logic                  out_primed,
	output logic [TIME_BITS-1:0]  out_now,
	output logic [CHANNELS-1:0]   out_bits,
	output mcsd_pkg::evt_t        evt
);
	import mcsd_pkg::*;

	logic                 raw_q;
	logic                 committed_q;
	logic [TIME_BITS-1:0] time_q;

	logic                 out_valid_q;
	logic                 out_primed_q;
	logic [TIME_BITS-1:0] out_now_q;
	logic [CHANNELS-1:0]  out_bits_q;
	evt_t                 evt_q;

	logic                 bit_in;
	logic                 qual;
	logic                 changed;
	logic [TIME_BITS-1:0] elapsed;
	logic                 commit_ok;
	logic                 fire;
	evt_t                 evt_d;

	always_comb begin
		bit_in    = in_bits[IDX];
		qual      = cfg.slot != '0;
		changed   = bit_in != raw_q;
		elapsed   = in_now - time_q;
		// a fresh raw change has zero stable time
		commit_ok = (cfg.req == '0) || (!changed && elapsed >= TIME_BITS'(cfg.req));
		fire      = in_valid && adv;
		evt_d          = '0;
		evt_d.channel  = CHAN_W'(IDX);
		evt_d.slot     = cfg.slot;
		evt_d.occupied = bit_in;
		if (!in_valid)
			evt_d.valid = 1'b0;
		else if (!in_primed)
			evt_d.valid = qual;
		else
			evt_d.valid = qual && (bit_in != committed_q) && commit_ok;
		if (!evt_d.valid)
			evt_d = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q       <= 1'b0;
			committed_q <= 1'b0;
			time_q      <= '0;
			out_valid_q <= 1'b0;
			evt_q       <= '0;
		end else if (adv) begin
			out_valid_q <= in_valid;
			evt_q       <= evt_d;
			if (fire) begin
				if (!in_primed) begin
					raw_q       <= bit_in;
					committed_q <= bit_in;
					time_q      <= in_now;
				end else if (qual) begin
					if (changed) begin
						raw_q  <= bit_in;
						time_q <= in_now;
					end
					if (evt_d.valid)
						committed_q <= bit_in;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_primed_q <= in_primed;
			out_now_q    <= in_now;
			out_bits_q   <= in_bits;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_primed = out_primed_q;
	assign out_now    = out_now_q;
	assign out_bits   = out_bits_q;
	assign evt        = evt_q;

endmodule
